/* rtl/odo_pkg.sv */
// Shared constants and helper functions for the wheel odometry block.
// No dependencies; used by odo_cordic, odo_div and diff_drive_odometry.
package odo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  localparam logic [31:0] DIST_RST  = 32'd263867;
  localparam logic [23:0] TRACK_RST = 24'd1048576;
  localparam logic [19:0] MAXD_RST  = 20'd20000;

  localparam logic [1:0] REG_DIST  = 2'd0;
  localparam logic [1:0] REG_TRACK = 2'd1;
  localparam logic [1:0] REG_MAXD  = 2'd2;

  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
  localparam logic signed [32:0] HEAD_SCALE = 33'sd341782638;
  localparam logic signed [32:0] NS_PER_S   = 33'sd1000000000;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/odo_cordic.sv */
// Iterative CORDIC rotation: one micro-rotation per cycle, sine and cosine in Q2.30.
// Depends on odo_pkg for the arctangent table and gain.
module odo_cordic import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  localparam int IW = $clog2(CORDIC_STEPS);

  logic              busy_r;
  logic [IW-1:0]     i_r;
  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, xs, ys, at, xf, yf;
  logic              flip_r;
  logic [31:0]       rot;
  logic signed [31:0] cos_r, sin_r;

  assign rot = (angle[31] ^ angle[30]) ? angle + 32'h80000000 : angle;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = {4'b0, atan_lut(5'(i_r))};
    if (!z_r[33]) begin
      x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
    end
    xf = flip_r ? -x_nxt : x_nxt;
    yf = flip_r ? -y_nxt : y_nxt;
    if (xf > ONE_Q30) xf = ONE_Q30;
    else if (xf < -ONE_Q30) xf = -ONE_Q30;
    if (yf > ONE_Q30) yf = ONE_Q30;
    else if (yf < -ONE_Q30) yf = -ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      flip_r <= angle[31] ^ angle[30];
      x_r    <= GAIN_Q30;
      y_r    <= '0;
      z_r    <= {{2{rot[31]}}, rot};
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 1'b1;
      if (i_r == IW'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        cos_r  <= xf[31:0];
        sin_r  <= yf[31:0];
      end
    end
  end

  assign busy  = busy_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;
endmodule

/* rtl/odo_div.sv */
// Restoring signed divider, one quotient bit per cycle, saturating 32-bit result.
// Depends on odo_pkg; a zero divisor yields zero.
module odo_div import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               busy,
  output logic signed [31:0] quo
);
  logic        busy_r, neg_r, zero_r;
  logic [5:0]  cnt_r;
  logic [63:0] n_r, d_r, rem_r, q_r, rem_sh, rem_nxt, q_nxt;
  logic        ge;
  logic signed [31:0] quo_r, fin;

  always_comb begin
    rem_sh  = {rem_r[62:0], n_r[63]};
    ge      = rem_sh >= d_r;
    rem_nxt = ge ? rem_sh - d_r : rem_sh;
    q_nxt   = {q_r[62:0], ge};
    if (zero_r) fin = '0;
    else if (neg_r) fin = (q_nxt > 64'd2147483648) ? 32'sh80000000 : -q_nxt[31:0];
    else fin = (q_nxt > 64'd2147483647) ? 32'sh7FFFFFFF : q_nxt[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      n_r    <= num[63] ? -num : num;
      d_r    <= den[63] ? -den : den;
      neg_r  <= num[63] ^ den[63];
      zero_r <= den == 64'sd0;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[62:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        quo_r  <= fin;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
endmodule

/* rtl/diff_drive_odometry.sv */
// Differential-drive wheel odometry: a preset word loads the reference wheel counts and time;
// a sample word with an oversized count change is taken in S_IDLE and dropped in S_CHECK; an
// accepted sample runs two 64-step velocity divisions on the one shared divider, two 24-step
// CORDIC runs and ten passes through the shared multiplier.
// Depends on odo_pkg, odo_cordic and odo_div.
module diff_drive_odometry import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [31:0] in_left_position,
  input  logic signed [31:0] in_right_position,
  input  logic [62:0]        in_timestamp_ns,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [31:0] out_orient_z,
  output logic signed [31:0] out_orient_w,
  output logic signed [31:0] out_lin_vel,
  output logic signed [31:0] out_ang_vel
);
  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MS, S_ME, S_MM, S_MH, S_ML, S_MT, S_HH, S_HL, S_HS,
    S_WC1, S_AX, S_AY, S_DV1, S_WD1, S_DV2, S_WD2, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] dist_r;
  logic [23:0] inv_r;
  logic [19:0] maxd_r;
  logic [31:0] prev_l_r, prev_r_r, lp_r, rp_r, heading_r, hinc_r;
  logic [62:0] prev_t_r, ts_r;
  logic signed [21:0] s_r, e_r;
  logic signed [63:0] dt_r, acc_r;
  logic signed [31:0] dc_r, dq_r, pos_x_r, pos_y_r, vl_r, va_r;
  logic signed [39:0] m_r;
  logic signed [61:0] t_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] mul_a, mul_b;
  logic [31:0] ul, ur, ml, mr;
  logic drop;

  logic out_valid_r;
  logic signed [31:0] ox_r, oy_r, oz_r, ow_r, olv_r, oav_r;

  logic cor_start, cor_busy, div_start, div_busy;
  logic [31:0] cor_angle;
  logic signed [31:0] cos_q, sin_q, quo;

  logic signed [65:0] r17, r14, tsum, r16, rx, ry;

  odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cor_start), .angle(cor_angle), .busy(cor_busy),
    .cos_q, .sin_q
  );

  odo_div u_div (
    .clk, .rst_n, .start(div_start), .num(prod_r[63:0]), .den(dt_r),
    .busy(div_busy), .quo
  );

  assign ul   = lp_r - prev_l_r;
  assign ur   = rp_r - prev_r_r;
  assign ml   = ul[31] ? -ul : ul;
  assign mr   = ur[31] ? -ur : ur;
  assign drop = (ml > {12'b0, maxd_r}) || (mr > {12'b0, maxd_r});

  assign cor_start = (state_r == S_CHECK && !drop) || state_r == S_AY;
  assign cor_angle = (state_r == S_CHECK) ? {heading_r[30:0], 1'b0} : heading_r + hinc_r;
  assign div_start = state_r == S_DV1 || state_r == S_DV2;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MS:  begin mul_a = {{11{s_r[21]}}, s_r}; mul_b = {1'b0, dist_r}; end
      S_ME:  begin mul_a = {{11{e_r[21]}}, e_r}; mul_b = {1'b0, dist_r}; end
      S_MH:  begin mul_a = {{9{m_r[39]}}, m_r[39:16]}; mul_b = {9'b0, inv_r}; end
      S_ML:  begin mul_a = {17'b0, m_r[15:0]}; mul_b = {9'b0, inv_r}; end
      S_HH:  begin mul_a = {{2{t_r[61]}}, t_r[61:31]}; mul_b = HEAD_SCALE; end
      S_HL:  begin mul_a = {2'b0, t_r[30:0]}; mul_b = HEAD_SCALE; end
      S_WC1: begin mul_a = {dc_r[31], dc_r}; mul_b = {cos_q[31], cos_q}; end
      S_AX:  begin mul_a = {dc_r[31], dc_r}; mul_b = {sin_q[31], sin_q}; end
      S_AY:  begin mul_a = {dc_r[31], dc_r}; mul_b = NS_PER_S; end
      S_WD1: begin mul_a = {dq_r[31], dq_r}; mul_b = NS_PER_S; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    r17  = (prod_r + 66'sd65536) >>> 17;
    r14  = (prod_r + 66'sd8192) >>> 14;
    tsum = (signed'({{2{acc_r[63]}}, acc_r}) + prod_r + 66'sd2) >>> 2;
    r16  = (signed'({{4{t_r[61]}}, t_r}) + 66'sd32768) >>> 16;
    rx   = signed'({{34{pos_x_r[31]}}, pos_x_r}) + ((prod_r + 66'sd536870912) >>> 30);
    ry   = signed'({{34{pos_y_r[31]}}, pos_y_r}) + ((prod_r + 66'sd536870912) >>> 30);
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dist_r      <= DIST_RST;
      inv_r       <= TRACK_RST;
      maxd_r      <= MAXD_RST;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      prev_t_r    <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIST:  dist_r <= cfg_data;
          REG_TRACK: inv_r  <= cfg_data[23:0];
          REG_MAXD:  maxd_r <= cfg_data[19:0];
          default:   ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          if (!in_kind) begin
            prev_l_r <= in_left_position;
            prev_r_r <= in_right_position;
            prev_t_r <= in_timestamp_ns;
          end else begin
            lp_r    <= in_left_position;
            rp_r    <= in_right_position;
            ts_r    <= in_timestamp_ns;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (drop) state_r <= S_IDLE;
          else begin
            s_r      <= 22'(signed'(ul)) + 22'(signed'(ur));
            e_r      <= 22'(signed'(ur)) - 22'(signed'(ul));
            dt_r     <= {1'b0, ts_r} - {1'b0, prev_t_r};
            prev_l_r <= lp_r;
            prev_r_r <= rp_r;
            prev_t_r <= ts_r;
            state_r  <= S_MS;
          end
        end
        S_MS: state_r <= S_ME;
        S_ME: begin dc_r <= sat32(r17); state_r <= S_MM; end
        S_MM: begin m_r <= r14[39:0]; state_r <= S_MH; end
        S_MH: state_r <= S_ML;
        S_ML: begin acc_r <= {prod_r[47:0], 16'b0}; state_r <= S_MT; end
        S_MT: begin t_r <= tsum[61:0]; state_r <= S_HH; end
        S_HH: begin dq_r <= sat32(r16); state_r <= S_HL; end
        S_HL: begin acc_r <= {prod_r[32:0], 31'b0}; state_r <= S_HS; end
        S_HS: begin
          hinc_r  <= 32'((acc_r + prod_r[63:0]) >>> 32);
          state_r <= S_WC1;
        end
        S_WC1: if (!cor_busy) state_r <= S_AX;
        S_AX: begin pos_x_r <= sat32(rx); state_r <= S_AY; end
        S_AY: begin
          pos_y_r   <= sat32(ry);
          heading_r <= heading_r + hinc_r;
          state_r   <= S_DV1;
        end
        S_DV1: state_r <= S_WD1;
        S_WD1: if (!div_busy) begin vl_r <= quo; state_r <= S_DV2; end
        S_DV2: state_r <= S_WD2;
        S_WD2: if (!div_busy && !cor_busy) begin
          va_r    <= quo;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || !out_stall) begin
          out_valid_r <= 1'b1;
          ox_r        <= pos_x_r;
          oy_r        <= pos_y_r;
          oz_r        <= sin_q;
          ow_r        <= cos_q;
          olv_r       <= vl_r;
          oav_r       <= va_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = state_r != S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_pose_x   = ox_r;
  assign out_pose_y   = oy_r;
  assign out_orient_z = oz_r;
  assign out_orient_w = ow_r;
  assign out_lin_vel  = olv_r;
  assign out_ang_vel  = oav_r;
endmodule

/* rtl/odo_checker.sv */
// Port-level checks for diff_drive_odometry, attached by bind.
// Depends only on the top level's ports.
module odo_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_kind,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pose_x,
  input logic signed [31:0] out_orient_z
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pose_x))
    else $error("stalled word changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind |=> in_stall)
    else $error("sample word not processed");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_orient_z <= 32'sd1073741824 && out_orient_z >= -32'sd1073741824))
    else $error("orientation out of range");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("reset state wrong");
endmodule

bind diff_drive_odometry odo_checker u_odo_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_kind, .out_valid, .out_stall,
  .out_pose_x, .out_orient_z
);
